// ----- rtl/dsdr_pkg.sv -----
`timescale 1ns / 1ps
// dsdr_pkg: shared constants, codes and state type for the dirty span refresh block
// no dependencies

package dsdr_pkg;

    localparam int LINE_BYTES = 32;
    localparam int MAX_LINES  = 128;
    localparam int COL_W      = $clog2(LINE_BYTES);
    localparam int ROW_W      = $clog2(MAX_LINES);
    localparam int SHADOW_DEPTH = LINE_BYTES * MAX_LINES;
    localparam int SHADOW_AW  = COL_W + ROW_W;

    localparam int BPL_W   = 6;
    localparam int LINES_W = 8;
    localparam int ADDR_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] KIND_SET_ADDR   = 2'd0;
    localparam logic [1:0] KIND_AUTO_START = 2'd1;
    localparam logic [1:0] KIND_DATA       = 2'd2;
    localparam logic [1:0] KIND_AUTO_RESET = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_LINE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAPHIC_BASE   = 2'd2;

    localparam logic [BPL_W-1:0]   BPL_RESET   = 6'd30;
    localparam logic [LINES_W-1:0] LINES_RESET = 8'd64;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CMP,
        ST_ADDR,
        ST_START,
        ST_RD,
        ST_DATA,
        ST_RESET
    } state_t;

endpackage

// ----- rtl/dsdr_ram.sv -----
`timescale 1ns / 1ps
// dsdr_ram: generic single write port, single read port ram with registered read
// no dependencies

module dsdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/dirty_span_display_refresh.sv -----
`timescale 1ns / 1ps
// dirty_span_display_refresh: compares incoming framebuffer bytes with a shadow ram and
// emits a set-address / auto-write run for the changed span of each line
// depends on dsdr_pkg and dsdr_ram
//
// each pixel byte takes a shadow ram read, then a compare; a line with a change adds set-address
// and auto-start, per span byte a line buffer read then output and shadow write, and auto-reset
// the set-address result is registered from ST_ADDR, which follows ST_CMP on the line's last byte
// reset: a clearing pass zeroes all 4096 shadow ram entries; pixel input stalls meanwhile,
// configuration writes are taken at any time

module dirty_span_display_refresh (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  logic [dsdr_pkg::BYTE_W-1:0]       pixel_byte,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [1:0]                        kind,
    output logic [dsdr_pkg::ADDR_W-1:0]       payload,
    output logic                              run_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dsdr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dsdr_pkg::ADDR_W-1:0]       cfg_data
);

    import dsdr_pkg::*;

    state_t state_reg, state_next;

    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [COL_W-1:0]     first_reg, first_next;
    logic [COL_W-1:0]     last_reg, last_next;
    logic                 seen_reg, seen_next;
    logic [COL_W-1:0]     span_reg, span_next;
    logic [SHADOW_AW-1:0] clr_reg, clr_next;
    logic [BYTE_W-1:0]    byte_reg;

    logic [BPL_W-1:0]     bpl_reg;
    logic [LINES_W-1:0]   lines_reg;
    logic [ADDR_W-1:0]    base_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           kind_reg, kind_next;
    logic [ADDR_W-1:0]    payload_reg, payload_next;
    logic                 last_out_reg, last_out_next;

    logic                 accept;
    logic                 out_free;
    logic                 load;
    logic [BPL_W-1:0]     bpl_eff;
    logic [LINES_W-1:0]   lines_eff;
    logic [ROW_W-1:0]     row_adv;
    logic [ROW_W+BPL_W-1:0] row_prod;
    logic [ADDR_W-1:0]    set_addr;
    logic                 diff;
    logic                 end_line;

    logic                 sh_we;
    logic [SHADOW_AW-1:0] sh_waddr;
    logic [BYTE_W-1:0]    sh_wdata;
    logic [BYTE_W-1:0]    sh_rdata;
    logic                 lb_re;
    logic [BYTE_W-1:0]    lb_rdata;

    dsdr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SHADOW_DEPTH)
    ) u_shadow (
        .clk   (clk),
        .we    (sh_we),
        .waddr (sh_waddr),
        .wdata (sh_wdata),
        .re    (accept),
        .raddr ({row_reg, col_reg}),
        .rdata (sh_rdata)
    );

    dsdr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_BYTES)
    ) u_line (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (pixel_byte),
        .re    (lb_re),
        .raddr (span_reg),
        .rdata (lb_rdata)
    );

    // effective configuration
    always_comb
    begin
        priority if (bpl_reg == '0)
        begin
            bpl_eff = BPL_W'(1);
        end
        else if (bpl_reg > BPL_W'(LINE_BYTES))
        begin
            bpl_eff = BPL_W'(LINE_BYTES);
        end
        else
        begin
            bpl_eff = bpl_reg;
        end

        priority if (lines_reg == '0)
        begin
            lines_eff = LINES_W'(1);
        end
        else if (lines_reg > LINES_W'(MAX_LINES))
        begin
            lines_eff = LINES_W'(MAX_LINES);
        end
        else
        begin
            lines_eff = lines_reg;
        end
    end

    assign row_adv  = ((LINES_W'(row_reg) + LINES_W'(1)) >= lines_eff) ? '0 : row_reg + ROW_W'(1);
    assign row_prod = (ROW_W+BPL_W)'(row_reg) * (ROW_W+BPL_W)'(bpl_eff);
    assign set_addr = base_reg + ADDR_W'(row_prod) + ADDR_W'(first_reg);
    assign diff     = byte_reg != sh_rdata;
    assign end_line = (BPL_W'(col_reg) + BPL_W'(1)) >= bpl_eff;

    assign accept   = pixel_valid && !pixel_stall;
    assign pixel_stall = state_reg != ST_IDLE;
    assign out_free = !out_valid_reg || !result_stall;
    assign cfg_ready = 1'b1;

    assign result_valid = out_valid_reg;
    assign kind         = kind_reg;
    assign payload      = payload_reg;
    assign run_last     = last_out_reg;

    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        seen_next     = seen_reg;
        span_next     = span_reg;
        clr_next      = clr_reg;
        load          = 1'b0;
        kind_next     = kind_reg;
        payload_next  = payload_reg;
        last_out_next = last_out_reg;
        sh_we         = 1'b0;
        sh_waddr      = {row_reg, span_reg};
        sh_wdata      = lb_rdata;
        lb_re         = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                sh_we    = 1'b1;
                sh_waddr = clr_reg;
                sh_wdata = '0;
                clr_next = clr_reg + SHADOW_AW'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (diff)
                begin
                    last_next = col_reg;
                    seen_next = 1'b1;
                    if (!seen_reg)
                    begin
                        first_next = col_reg;
                    end
                end
                if (end_line)
                begin
                    if (diff || seen_reg)
                    begin
                        state_next = ST_ADDR;
                    end
                    else
                    begin
                        first_next = '0;
                        last_next  = '0;
                        seen_next  = 1'b0;
                        col_next   = '0;
                        row_next   = row_adv;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    col_next   = col_reg + COL_W'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_ADDR:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    kind_next     = KIND_SET_ADDR;
                    payload_next  = set_addr;
                    last_out_next = 1'b0;
                    span_next     = first_reg;
                    state_next    = ST_START;
                end
            end
            ST_START:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    kind_next     = KIND_AUTO_START;
                    payload_next  = '0;
                    last_out_next = 1'b0;
                    state_next    = ST_RD;
                end
            end
            ST_RD:
            begin
                lb_re      = 1'b1;
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    kind_next     = KIND_DATA;
                    payload_next  = ADDR_W'(lb_rdata);
                    last_out_next = 1'b0;
                    sh_we         = 1'b1;
                    if (span_reg == last_reg)
                    begin
                        state_next = ST_RESET;
                    end
                    else
                    begin
                        span_next  = span_reg + COL_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            ST_RESET:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    kind_next     = KIND_AUTO_RESET;
                    payload_next  = '0;
                    last_out_next = 1'b1;
                    first_next    = '0;
                    last_next     = '0;
                    seen_next     = 1'b0;
                    col_next      = '0;
                    row_next      = row_adv;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        priority if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            col_reg       <= '0;
            row_reg       <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            seen_reg      <= 1'b0;
            span_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            bpl_reg       <= BPL_RESET;
            lines_reg     <= LINES_RESET;
            base_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            seen_reg      <= seen_next;
            span_reg      <= span_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_BYTES_PER_LINE: bpl_reg   <= cfg_data[BPL_W-1:0];
                    REG_LINE_COUNT:     lines_reg <= cfg_data[LINES_W-1:0];
                    REG_GRAPHIC_BASE:   base_reg  <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= pixel_byte;
        end
        kind_reg     <= kind_next;
        payload_reg  <= payload_next;
        last_out_reg <= last_out_next;
    end

endmodule

// ----- sim/tb_dirty_span_display_refresh.sv -----
`timescale 1ns / 1ps
// tb_dirty_span_display_refresh: self-checking bench for the dirty span refresh block,
// a directed table then random bursts, each transfer checked against a local line predictor or typed addresses
// depends on dsdr_pkg and dirty_span_display_refresh

module tb_dirty_span_display_refresh;

    import dsdr_pkg::*;

    localparam int HOLD_CYCLES     = 300;
    localparam int IDLE_GAP        = 10;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int RANDOM_ITEMS    = 80;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_RANGE = 2'd3;

    typedef enum logic [1:0] {CHK_PREDICT, CHK_QUIET, CHK_SINGLE} chk_e;
    typedef enum logic [1:0] {ROW_WRITE, ROW_PIXEL} row_op_e;

    typedef struct packed {
        row_op_e               op;
        logic [CFG_IDX_W-1:0]  idx;
        logic [ADDR_W-1:0]     value;
        chk_e                  chk;
        logic [ADDR_W-1:0]     addr;
    } script_row_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] payload;
        logic              run_last;
    } refresh_item_t;

    // single-byte lines give typed addresses; the mid-line rows rely on the predictor
    script_row_t script [0:24] = '{
        '{ROW_WRITE, REG_BYTES_PER_LINE, 16'd1,      CHK_PREDICT, 16'h0000},
        '{ROW_PIXEL, REG_OUT_OF_RANGE,   16'h0000,   CHK_QUIET,   16'h0000},
        '{ROW_PIXEL, REG_OUT_OF_RANGE,   16'h00FF,   CHK_SINGLE,  16'h0001},
        '{ROW_WRITE, REG_BYTES_PER_LINE, 16'd0,      CHK_PREDICT, 16'h0000},
        '{ROW_PIXEL, REG_OUT_OF_RANGE,   16'h0080,   CHK_SINGLE,  16'h0002},
        '{ROW_WRITE, REG_GRAPHIC_BASE,   16'hFFFF,   CHK_PREDICT, 16'h0000},
        '{ROW_PIXEL, REG_OUT_OF_RANGE,   16'h0001,   CHK_SINGLE,  16'h0002},
        '{ROW_WRITE, REG_LINE_COUNT,     16'd0,      CHK_PREDICT, 16'h0000},
        '{ROW_PIXEL, REG_OUT_OF_RANGE,   16'h0055,   CHK_SINGLE,  16'h0003},
        '{ROW_PIXEL, REG_OUT_OF_RANGE,   16'h0055,   CHK_SINGLE,  16'hFFFF},
        '{ROW_PIXEL, REG_OUT_OF_RANGE,   16'h0055,   CHK_QUIET,   16'h0000},
        '{ROW_WRITE, REG_OUT_OF_RANGE,   16'h0005,   CHK_PREDICT, 16'h0000},
        '{ROW_PIXEL, REG_OUT_OF_RANGE,   16'h00AA,   CHK_SINGLE,  16'hFFFF},
        '{ROW_WRITE, REG_LINE_COUNT,     16'd255,    CHK_PREDICT, 16'h0000},
        '{ROW_WRITE, REG_BYTES_PER_LINE, 16'd63,     CHK_PREDICT, 16'h0000},
        '{ROW_WRITE, REG_GRAPHIC_BASE,   16'h1234,   CHK_PREDICT, 16'h0000},
        '{ROW_PIXEL, REG_OUT_OF_RANGE,   16'h00AA,   CHK_PREDICT, 16'h0000},
        '{ROW_PIXEL, REG_OUT_OF_RANGE,   16'h0000,   CHK_PREDICT, 16'h0000},
        '{ROW_PIXEL, REG_OUT_OF_RANGE,   16'h003C,   CHK_PREDICT, 16'h0000},
        '{ROW_PIXEL, REG_OUT_OF_RANGE,   16'h0000,   CHK_PREDICT, 16'h0000},
        '{ROW_PIXEL, REG_OUT_OF_RANGE,   16'h00C3,   CHK_PREDICT, 16'h0000},
        '{ROW_WRITE, REG_BYTES_PER_LINE, 16'd2,      CHK_PREDICT, 16'h0000},
        '{ROW_PIXEL, REG_OUT_OF_RANGE,   16'h0000,   CHK_PREDICT, 16'h0000},
        '{ROW_PIXEL, REG_OUT_OF_RANGE,   16'h00FF,   CHK_PREDICT, 16'h0000},
        '{ROW_PIXEL, REG_OUT_OF_RANGE,   16'h0001,   CHK_PREDICT, 16'h0000}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_stall;
    logic [BYTE_W-1:0]     pixel_byte = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [1:0]            kind;
    logic [ADDR_W-1:0]     payload;
    logic                  run_last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ADDR_W-1:0]     cfg_data = '0;

    chk_e                  pix_chk = CHK_PREDICT;
    logic [ADDR_W-1:0]     pix_addr = '0;

    // line predictor state
    logic [BYTE_W-1:0]     shadow_mem [SHADOW_DEPTH] = '{default: 8'h00};
    logic [BYTE_W-1:0]     line_mem [LINE_BYTES] = '{default: 8'h00};
    int                    col_at = 0;
    int                    row_at = 0;
    int                    span_lo = 0;
    int                    span_hi = 0;
    bit                    span_open = 1'b0;
    logic [BPL_W-1:0]      bpl_reg = BPL_RESET;
    logic [LINES_W-1:0]    lines_reg = LINES_RESET;
    logic [ADDR_W-1:0]     base_reg = '0;

    refresh_item_t         fresh_q [$];
    refresh_item_t         expect_q [$];
    refresh_item_t         want;

    int                    fail_count = 0;
    int                    pixels_sent = 0;
    int                    results_seen = 0;
    int                    runs_seen = 0;
    int                    writes_done = 0;
    int                    idle_cycles = 0;
    int                    burst_left = 0;
    bit                    moved;
    bit                    hold_req = 1'b0;

    dirty_span_display_refresh DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_byte   (pixel_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .payload      (payload),
        .run_last     (run_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic void fold_pixel(input logic [BYTE_W-1:0] b);
        int len;
        int rows;
        int col;
        int row;
        int at;
        len  = (bpl_reg == 0) ? 1 : (bpl_reg > LINE_BYTES) ? LINE_BYTES : int'(bpl_reg);
        rows = (lines_reg == 0) ? 1 : (lines_reg > MAX_LINES) ? MAX_LINES : int'(lines_reg);
        col  = (col_at >= LINE_BYTES) ? LINE_BYTES - 1 : col_at;
        row  = (row_at >= MAX_LINES) ? MAX_LINES - 1 : row_at;
        line_mem[col] = b;
        if (b != shadow_mem[row * LINE_BYTES + col])
        begin
            if (!span_open)
                span_lo = col;
            span_hi = col;
            span_open = 1'b1;
        end
        if (col + 1 >= len)
        begin
            if (span_open)
            begin
                fresh_q.push_back('{KIND_SET_ADDR,
                                   16'(int'(base_reg) + row * len + span_lo), 1'b0});
                fresh_q.push_back('{KIND_AUTO_START, 16'h0000, 1'b0});
                for (at = span_lo; at <= span_hi; at++)
                begin
                    fresh_q.push_back('{KIND_DATA, {8'h00, line_mem[at]}, 1'b0});
                    shadow_mem[row * LINE_BYTES + at] = line_mem[at];
                end
                fresh_q.push_back('{KIND_AUTO_RESET, 16'h0000, 1'b1});
            end
            span_open = 1'b0;
            span_lo = 0;
            span_hi = 0;
            col_at = 0;
            row_at = (row + 1 >= rows) ? 0 : row + 1;
        end
        else
        begin
            col_at = col + 1;
            row_at = row;
        end
    endfunction

    // transfer monitor and scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BYTES_PER_LINE: bpl_reg = cfg_data[BPL_W-1:0];
                    REG_LINE_COUNT:     lines_reg = cfg_data[LINES_W-1:0];
                    REG_GRAPHIC_BASE:   base_reg = cfg_data;
                    default: ;
                endcase
                writes_done++;
                moved = 1'b1;
            end
            if (pixel_valid && !pixel_stall)
            begin
                fresh_q.delete();
                fold_pixel(pixel_byte);
                case (pix_chk)
                    CHK_PREDICT:
                        foreach (fresh_q[i])
                            expect_q.push_back(fresh_q[i]);
                    CHK_SINGLE:
                    begin
                        expect_q.push_back('{KIND_SET_ADDR, pix_addr, 1'b0});
                        expect_q.push_back('{KIND_AUTO_START, 16'h0000, 1'b0});
                        expect_q.push_back('{KIND_DATA, {8'h00, pixel_byte}, 1'b0});
                        expect_q.push_back('{KIND_AUTO_RESET, 16'h0000, 1'b1});
                    end
                    default: ;
                endcase
                pixels_sent++;
                moved = 1'b1;
            end
            if (result_valid && !result_stall)
            begin
                moved = 1'b1;
                if (expect_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d payload %h run_last %b",
                           kind, payload, run_last);
                    fail_count++;
                end
                else
                begin
                    want = expect_q.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        fail_count++;
                    end
                    if (payload !== want.payload)
                    begin
                        $error("payload: expected %h, got %h", want.payload, payload);
                        fail_count++;
                    end
                    if (run_last !== want.run_last)
                    begin
                        $error("run_last: expected %b, got %b", want.run_last, run_last);
                        fail_count++;
                    end
                    if (want.run_last)
                        runs_seen++;
                    results_seen++;
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // receiver stall patterns, plus one long hold on request
    initial
    begin
        int pattern;
        int left;
        bit toggle;
        pattern = 0;
        left = 0;
        toggle = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if (left == 0)
            begin
                pattern = $urandom_range(0, 3);
                left = $urandom_range(16, 64);
            end
            left--;
            toggle = ~toggle;
            case (pattern)
                0:       result_stall <= 1'b0;
                1:       result_stall <= ($urandom_range(0, 3) == 0);
                2:       result_stall <= toggle;
                default: result_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles with no transfer", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                pixel_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic send_pixel(input logic [BYTE_W-1:0] b, input chk_e chk,
                              input logic [ADDR_W-1:0] addr);
        pixel_byte <= b;
        pix_chk <= chk;
        pix_addr <= addr;
        pixel_valid <= 1'b1;
        @(posedge clk);
        while (!(pixel_valid && !pixel_stall))
            @(posedge clk);
        @(negedge clk);
        pace();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready))
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // drain outstanding results; lines without a change leave no trace, so pad with an idle gap
    task automatic wait_idle();
        pixel_valid <= 1'b0;
        while (expect_q.size() != 0)
            @(negedge clk);
        repeat (IDLE_GAP) @(negedge clk);
    endtask

    initial
    begin
        int i;
        int n;
        int phase;
        int random_items;
        logic [2:0] mask;
        logic [BYTE_W-1:0] b;

        random_items = 0;
        phase = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[r])
        begin
            if (script[r].op == ROW_WRITE)
            begin
                wait_idle();
                write_reg(script[r].idx, script[r].value);
            end
            else
                send_pixel(script[r].value[BYTE_W-1:0], script[r].chk, script[r].addr);
        end

        while (random_items < RANDOM_ITEMS)
        begin
            wait_idle();
            mask = 3'($urandom_range(1, 7));
            if (mask[0])
            begin
                case ($urandom_range(0, 9))
                    0:       write_reg(REG_BYTES_PER_LINE, 16'd0);
                    1:       write_reg(REG_BYTES_PER_LINE, 16'd32);
                    2:       write_reg(REG_BYTES_PER_LINE, 16'd63);
                    3:       write_reg(REG_BYTES_PER_LINE, 16'($urandom_range(33, 62)));
                    default: write_reg(REG_BYTES_PER_LINE, 16'($urandom_range(1, 6)));
                endcase
            end
            if (mask[1])
            begin
                case ($urandom_range(0, 7))
                    0:       write_reg(REG_LINE_COUNT, 16'd0);
                    1:       write_reg(REG_LINE_COUNT, 16'd128);
                    2:       write_reg(REG_LINE_COUNT, 16'd255);
                    3:       write_reg(REG_LINE_COUNT, 16'($urandom_range(129, 254)));
                    default: write_reg(REG_LINE_COUNT, 16'($urandom_range(1, 4)));
                endcase
            end
            if (mask[2])
            begin
                case ($urandom_range(0, 3))
                    0:       write_reg(REG_GRAPHIC_BASE, 16'hFFFF - 16'($urandom_range(0, 16)));
                    1:       write_reg(REG_GRAPHIC_BASE, 16'h0000);
                    default: write_reg(REG_GRAPHIC_BASE, 16'($urandom_range(0, 65535)));
                endcase
            end
            if ($urandom_range(0, 5) == 0)
                write_reg(REG_OUT_OF_RANGE, 16'($urandom_range(0, 65535)));
            // one-byte lines of changed bytes keep results waiting on the receiver during the long hold
            if (phase == 1)
            begin
                write_reg(REG_BYTES_PER_LINE, 16'd1);
                hold_req = 1'b1;
            end
            n = $urandom_range(4, 30);
            for (i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 5))
                    0, 1:    b = shadow_mem[row_at * LINE_BYTES + col_at];
                    2:       b = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                if (phase == 1)
                    b = ~shadow_mem[row_at * LINE_BYTES + col_at];
                send_pixel(b, CHK_PREDICT, 16'h0000);
                random_items++;
            end
            phase++;
        end

        wait_idle();
        repeat (IDLE_GAP) @(negedge clk);

        $display("run covered %0d pixel bytes, %0d refresh runs, %0d results, %0d register writes",
                 pixels_sent, runs_seen, results_seen, writes_done);
        $display("over %0d random setting phases with a %0d cycle receiver hold",
                 phase, HOLD_CYCLES);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
